[src/firc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and codes for the circular-delay FIR filter.
// No dependencies; used by every module of the block but firc_ram.
package firc_pkg;

	// Filter dimensions.
	localparam int TAPS         = 33;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 16;

	// Derived widths.
	localparam int TAP_WIDTH  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_WIDTH  = PROD_WIDTH + TAP_WIDTH + 1;

	// Stream field layout.
	localparam int INDEX_WIDTH     = 6;
	localparam int SAMPLE_LSB      = 0;
	localparam int INDEX_LSB       = SAMPLE_LSB + SAMPLE_WIDTH;
	localparam int COEF_LSB        = INDEX_LSB + INDEX_WIDTH;
	localparam int IN_FIELDS_WIDTH = COEF_LSB + COEF_WIDTH;
	localparam int IN_TDATA_WIDTH  = ((IN_FIELDS_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;

	// Request kinds carried in the input tuser.
	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_COEF   = 1'b1
	} req_kind_t;

	// One classified request as held in the queue.
	typedef struct packed {
		req_kind_t                      kind;
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic [TAP_WIDTH-1:0]           tap;
		logic signed [COEF_WIDTH-1:0]   coef;
	} item_t;

	// Status of the execution engine.
	typedef struct packed {
		logic                 busy;
		logic [TAP_WIDTH-1:0] pos;
	} back_stat_t;

endpackage

[src/firc_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module firc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 33
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/firc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts stream requests, classifies them and queues them.
// Depends on firc_pkg.
module firc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Bits from 0 up: sample_in, coef_index, coef_value, zero padding.
	input  logic [firc_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
	// req_type.
	input  logic                                  s_axis_tuser,
	output logic                                  q_valid,
	input  logic                                  q_ready,
	output firc_pkg::item_t                       q_item
);
	import firc_pkg::*;

	item_t      fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      item_in;
	logic       index_ok;
	logic       accept;
	logic       push;
	logic       pop;

	// Unpack and classify the incoming request.
	always_comb begin
		item_in.kind   = req_kind_t'(s_axis_tuser);
		item_in.sample = s_axis_tdata[SAMPLE_LSB +: SAMPLE_WIDTH];
		item_in.tap    = TAP_WIDTH'(s_axis_tdata[INDEX_LSB +: INDEX_WIDTH]);
		item_in.coef   = s_axis_tdata[COEF_LSB +: COEF_WIDTH];
		index_ok       = int'(s_axis_tdata[INDEX_LSB +: INDEX_WIDTH]) < TAPS;
	end

	// Coefficient writes to a tap that does not exist are dropped here.
	assign s_axis_tready = (count_q != 2'd2);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign push          = accept & ((item_in.kind == REQ_SAMPLE) | index_ok);
	assign q_valid       = (count_q != 2'd0);
	assign pop           = q_valid & q_ready;
	assign q_item        = fifo_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/firc_back.sv]
`timescale 1ns / 1ps
// Back end: coefficient and delay-line memories, the multiply-accumulate
// engine, rounding and saturation, and the result register. Depends on
// firc_pkg and firc_ram.
module firc_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	output logic                                  q_ready,
	input  firc_pkg::item_t                       q_item,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// Bits from 0 up: filtered, zero padding.
	output logic [firc_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
	// clipped.
	output logic                                  m_axis_tuser,
	output firc_pkg::back_stat_t                  stat
);
	import firc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MAC   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
		{{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
		{{(ACC_WIDTH-1){1'b0}}, 1'b1} << (COEF_WIDTH-2);
	localparam logic [TAP_WIDTH-1:0] LAST_TAP = TAP_WIDTH'(TAPS-1);

	state_t                          state_q;
	logic [TAP_WIDTH-1:0]            pos_q;
	logic [TAP_WIDTH-1:0]            tap_q;
	logic [TAP_WIDTH-1:0]            rpos_q;
	logic [TAPS-1:0]                 coef_vld_q;
	logic [TAPS-1:0]                 samp_vld_q;
	logic                            rd_s1;
	logic                            last_s1;
	logic                            cv_s1;
	logic                            sv_s1;
	logic                            rd_s2;
	logic                            last_s2;
	logic signed [PROD_WIDTH-1:0]    prod_s2;
	logic signed [ACC_WIDTH-1:0]     acc_q;
	logic                            out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  filtered_q;
	logic                            clipped_q;
	logic                            pop;
	logic                            coef_we;
	logic                            samp_we;
	logic [COEF_WIDTH-1:0]           coef_rd;
	logic [SAMPLE_WIDTH-1:0]         samp_rd;
	logic signed [COEF_WIDTH-1:0]    coef_op;
	logic signed [SAMPLE_WIDTH-1:0]  samp_op;
	logic signed [ACC_WIDTH-1:0]     rounded;
	logic signed [ACC_WIDTH-1:0]     shifted;
	logic signed [SAMPLE_WIDTH-1:0]  sat_value;
	logic                            sat_clip;
	logic                            out_free;

	assign q_ready  = (state_q == S_IDLE);
	assign pop      = q_valid & q_ready;
	assign coef_we  = pop & (q_item.kind == REQ_COEF);
	assign samp_we  = pop & (q_item.kind == REQ_SAMPLE);
	assign out_free = ~out_valid_q | m_axis_tready;

	// Coefficient table and delay line.
	firc_ram #(.WIDTH(COEF_WIDTH), .DEPTH(TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (q_item.tap),
		.wdata (q_item.coef),
		.raddr (tap_q),
		.rdata (coef_rd)
	);

	firc_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(TAPS)) u_delay_ram (
		.clk   (clk),
		.we    (samp_we),
		.waddr (pos_q),
		.wdata (q_item.sample),
		.raddr (rpos_q),
		.rdata (samp_rd)
	);

	// Entries never written since reset read as zero.
	assign coef_op = cv_s1 ? coef_rd : '0;
	assign samp_op = sv_s1 ? samp_rd : '0;

	// Round half up, shift back to the sample format and saturate.
	always_comb begin
		rounded = acc_q + ROUND_BIAS;
		shifted = rounded >>> (COEF_WIDTH-1);
		if (shifted > SAT_HI) begin
			sat_value = SAT_HI[SAMPLE_WIDTH-1:0];
			sat_clip  = 1'b1;
		end else if (shifted < SAT_LO) begin
			sat_value = SAT_LO[SAMPLE_WIDTH-1:0];
			sat_clip  = 1'b1;
		end else begin
			sat_value = shifted[SAMPLE_WIDTH-1:0];
			sat_clip  = 1'b0;
		end
	end

	// Sequencer, valid bits and write position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pos_q      <= '0;
			tap_q      <= '0;
			rpos_q     <= '0;
			coef_vld_q <= '0;
			samp_vld_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (coef_we) begin
						coef_vld_q[q_item.tap] <= 1'b1;
					end
					if (samp_we) begin
						samp_vld_q[pos_q] <= 1'b1;
						tap_q             <= '0;
						rpos_q            <= pos_q;
						state_q           <= S_MAC;
					end
				end
				S_MAC: begin
					tap_q  <= tap_q + 1'b1;
					rpos_q <= (rpos_q == '0) ? LAST_TAP : rpos_q - 1'b1;
					if (tap_q == LAST_TAP) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (rd_s2 && last_s2) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						pos_q   <= (pos_q == LAST_TAP) ? '0 : pos_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Read and multiply stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			last_s1 <= 1'b0;
			rd_s2   <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			rd_s1   <= (state_q == S_MAC);
			last_s1 <= (state_q == S_MAC) && (tap_q == LAST_TAP);
			rd_s2   <= rd_s1;
			last_s2 <= last_s1;
		end
	end

	// Read stage valid flags and the product register.
	always_ff @(posedge clk) begin
		cv_s1   <= coef_vld_q[tap_q];
		sv_s1   <= samp_vld_q[rpos_q];
		prod_s2 <= coef_op * samp_op;
	end

	// Accumulator, cleared when a sample starts.
	always_ff @(posedge clk) begin
		if (samp_we) begin
			acc_q <= '0;
		end else if (rd_s2) begin
			acc_q <= acc_q + {{(ACC_WIDTH-PROD_WIDTH){prod_s2[PROD_WIDTH-1]}}, prod_s2};
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			filtered_q <= sat_value;
			clipped_q  <= sat_clip;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_WIDTH'(filtered_q);
	assign m_axis_tuser  = clipped_q;
	assign stat.busy     = (state_q != S_IDLE);
	assign stat.pos      = pos_q;

endmodule

[src/fir_filter_circular_delay.sv]
`timescale 1ns / 1ps
// Top level of the 33-tap direct-form FIR filter with circular delay line.
// Depends on firc_pkg, firc_front, firc_back and firc_ram.
//
//  Channel  Direction  Payload                                  Sideband
//  s_axis   in         sample_in, coef_index, coef_value        tuser: req_type
//  m_axis   out        filtered                                 tuser: clipped
//
// A coefficient request is written while the engine is idle; a sample request
// is written, then takes one multiply-accumulate per tap through a single
// multiplier and one read port per memory, a pipeline drain, and a state
// that rounds and loads the result register.
// A two-entry queue takes requests while the engine works or a result waits.
// After reset both memories read as zero through per-entry valid bits, so no
// clearing pass is needed and requests are taken at once.
module fir_filter_circular_delay (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Bits from 0 up: sample_in, coef_index, coef_value, zero padding.
	input  logic [firc_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
	// req_type.
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// Bits from 0 up: filtered, zero padding.
	output logic [firc_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata,
	// clipped.
	output logic                                  m_axis_tuser
);
	import firc_pkg::*;

	logic       q_valid;
	logic       q_ready;
	item_t      q_item;
	back_stat_t stat;

	// Request intake and queue.
	firc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item)
	);

	// Filter engine and result register.
	firc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.stat          (stat)
	);

	// A clipped result carries one of the two saturation values.
	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
		(m_axis_tdata[SAMPLE_WIDTH-1:0] == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} ||
		 m_axis_tdata[SAMPLE_WIDTH-1:0] == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}))
		else $error("clipped result is not a saturation value");

	// The write position stays inside the delay line.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(stat.pos) < TAPS)
		else $error("write position beyond the delay line");

	// Only coefficient writes to existing taps reach the engine.
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && q_item.kind == REQ_COEF) |-> int'(q_item.tap) < TAPS)
		else $error("coefficient write to a missing tap was queued");

	// The engine takes no request while it is busy with a sample.
	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !q_ready)
		else $error("engine ready while busy");

endmodule
